@@ hdl/jig_pkg.sv @@
// Shared types and constants for the jittered interval generator.
`default_nettype none

package jig_pkg;

  // Generator constants.
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] ZERO_SEED    = 64'hA5A5_5A5A_5A5A_A5A5;

  // Band and tail constants.
  localparam logic [29:0] NS_PER_SEC   = 30'd1_000_000_000;
  localparam logic [6:0]  MAX_SECONDS  = 7'd30;
  localparam logic [5:0]  MEAN_DEFAULT = 6'd5;
  localparam logic [5:0]  MEAN_LIMIT   = 6'd60;

  // Tail reduction: floor(2^61 / 1e9) estimates the quotient from the upper draw word,
  // and the multiples of 1e9 finish the remainder by compare and subtract.
  localparam logic [31:0] RECIP_NS     = 32'h8970_5F41;
  localparam logic [33:0] NS_X4        = 34'd4_000_000_000;
  localparam logic [33:0] NS_X2        = 34'd2_000_000_000;
  localparam logic [33:0] NS_X1        = 34'd1_000_000_000;

  // Register map: index of each configuration register.
  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_SEED = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_XOR,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MOD,
    S_RCP0,
    S_RCP1,
    S_RCP2,
    S_SUB,
    S_OUT
  } fsm_e;

  // Position inside the output mix of one draw.
  typedef enum logic [1:0] {
    PH_PRE,
    PH_MID,
    PH_FIN
  } mix_phase_e;

endpackage

`default_nettype wire

@@ hdl/jig_mul.sv @@
// Shared 32x32 multiplier with a registered 64-bit product.
`default_nettype none

module jig_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ hdl/jig_rem.sv @@
// Two restoring remainder steps, consuming two dividend bits per call.
`default_nettype none

module jig_rem (
  input  logic [29:0] rem_i,
  input  logic [1:0]  bits_i,
  input  logic [29:0] div_i,
  output logic [29:0] rem_o
);

  logic [30:0] t0;
  logic [30:0] r1;
  logic [30:0] t1;
  logic [30:0] r2;

  always_comb begin
    t0    = {rem_i, bits_i[1]};
    r1    = (t0 >= {1'b0, div_i}) ? (t0 - {1'b0, div_i}) : t0;
    t1    = {r1[29:0], bits_i[0]};
    r2    = (t1 >= {1'b0, div_i}) ? (t1 - {1'b0, div_i}) : t1;
    rem_o = r2[29:0];
  end

endmodule

`default_nettype wire

@@ hdl/jittered_interval_generator_core.sv @@
// Top level of the jittered interval generator: sequencer, registers and APB port.
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------------------
// request   | in        | in_valid_i / in_ready_o    | draw_i
// schedule  | out       | out_valid_o / out_ready_i  | wait_seconds_o, tail_nanoseconds_o
// config    | in        | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// A request transaction with draw_i set makes two draws, one for the seconds and one for
// the tail. Each draw advances the generator state, then runs the xor-shift steps and
// the two 64-bit multiplies (each built from three products on one shared 32x32
// multiplier). The seconds draw then runs the remainder unit, which retires two dividend
// bits per cycle against the band span. The tail draw is reduced modulo 1e9: a reciprocal
// multiply estimates the quotient, a second multiply takes it back out and three
// compare-and-subtract steps finish. The OUT state then loads the output register;
// in_ready_o stays low from acceptance until then, and the load waits while the previous
// schedule is still unclaimed. A request with draw_i clear is accepted and yields nothing.
// rst_ni clears the generator state (the next draw reseeds), the seed register and the
// output valid, and returns the mean register to its default; no clearing pass is needed.

module jittered_interval_generator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                draw_i,
  // Schedule channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          wait_seconds_o,
  output logic [29:0]         tail_nanoseconds_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  import jig_pkg::*;

  // Configuration registers.
  logic [5:0]  mean_q;
  logic [63:0] seed_q;

  // Sequencer and datapath registers.
  fsm_e        fsm_q, fsm_d;
  mix_phase_e  phase_q, phase_d;
  logic [63:0] gen_q, gen_d;
  logic [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;
  logic [29:0] rem_q, rem_d;
  logic [33:0] red_q, red_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        draw_sel_q, draw_sel_d;
  logic [4:0]  lo_q, lo_d;
  logic [4:0]  span_q, span_d;
  logic [4:0]  secs_res_q, secs_res_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  out_secs_q, out_secs_d;
  logic [29:0] out_tail_q, out_tail_d;

  // Band derived from the mean register.
  logic [5:0]  mean_eff;
  logic [5:0]  half;
  logic [5:0]  band_lo6;
  logic [6:0]  band_hi7;
  logic [4:0]  band_lo;
  logic [4:0]  band_span;

  // Shared units.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mix_const;
  logic [29:0] divisor;
  logic [29:0] rem_next;
  logic [33:0] sub_k;
  logic [63:0] seed_mix;
  logic [63:0] gen_start;

  logic        cfg_write;

  // ---------------------------------------------------------------------------------------
  // Configuration port. Registers sit at byte addresses 0 and 8; bit 3 picks the register.
  // ---------------------------------------------------------------------------------------
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[3] == REG_SEED) ? seed_q : {58'd0, mean_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= MEAN_DEFAULT;
      seed_q <= 64'd0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_MEAN: mean_q <= pwdata[5:0];
        REG_SEED: seed_q <= pwdata;
        default:  mean_q <= mean_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Band: mean plus or minus half the mean, clipped to 1..30. A zero mean uses the default
  // and a mean above the limit saturates. The span never exceeds 30.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    mean_eff = mean_q;
    if (mean_eff == 6'd0) begin
      mean_eff = MEAN_DEFAULT;
    end
    if (mean_eff > MEAN_LIMIT) begin
      mean_eff = MEAN_LIMIT;
    end
    half = {1'b0, mean_eff[5:1]};
    if (half == 6'd0) begin
      half = 6'd1;
    end
    band_lo6 = mean_eff - half;
    if (band_lo6 == 6'd0) begin
      band_lo6 = 6'd1;
    end
    band_hi7 = {1'b0, mean_eff} + {1'b0, half};
    if (band_hi7 > MAX_SECONDS) begin
      band_hi7 = MAX_SECONDS;
    end
    if (band_hi7 < {1'b0, band_lo6}) begin
      band_hi7 = {1'b0, band_lo6};
    end
    band_lo   = band_lo6[4:0];
    band_span = band_hi7[4:0] - band_lo + 5'd1;
  end

  // ---------------------------------------------------------------------------------------
  // Shared units. The multiplier builds the low 64 bits of z * constant from three partial
  // products and also serves the tail reduction; the remainder unit reduces the seconds
  // draw two bits per cycle against the band span.
  // ---------------------------------------------------------------------------------------
  assign mix_const = (phase_q == PH_PRE) ? MIX_MUL_A : MIX_MUL_B;
  assign divisor   = {25'd0, span_q};

  always_comb begin
    unique case (fsm_q)
      S_MUL1: begin
        mul_a = z_q[63:32];
        mul_b = mix_const[31:0];
      end
      S_MUL2: begin
        mul_a = z_q[31:0];
        mul_b = mix_const[63:32];
      end
      // Quotient estimate: upper draw word times floor(2^61 / 1e9).
      S_RCP0: begin
        mul_a = z_q[63:32];
        mul_b = RECIP_NS;
      end
      // Low 32 bits of the estimate, which is the product shifted down by 29, times 1e9.
      // Its upper bits drop out modulo 2^34 because 1e9 is a multiple of four.
      S_RCP1: begin
        mul_a = mul_p[60:29];
        mul_b = {2'b00, NS_PER_SEC};
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mix_const[31:0];
      end
    endcase
  end

  // The estimate is at most seven short, so the partial remainder stays below 8e9 and three
  // compare-and-subtract steps of 4e9, 2e9 and 1e9 bring it below 1e9.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sub_k = NS_X4;
      2'd1:    sub_k = NS_X2;
      default: sub_k = NS_X1;
    endcase
  end

  jig_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  jig_rem u_rem (
    .rem_i  (rem_q),
    .bits_i (z_q[63:62]),
    .div_i  (divisor),
    .rem_o  (rem_next)
  );

  // A zero state means the generator is unseeded: it loads the seed mixed with the golden
  // constant, and the fixed constant replaces a mixed seed of zero.
  assign seed_mix  = seed_q ^ GOLDEN_GAMMA;
  assign gen_start = (gen_q != 64'd0) ? gen_q :
                     ((seed_mix == 64'd0) ? ZERO_SEED : seed_mix);

  // ---------------------------------------------------------------------------------------
  // Sequencer. Each draw walks ADV, then XOR/MUL0..MUL3 twice, then a final XOR. The first
  // draw then runs the remainder loop for the seconds, the second the tail reduction.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    fsm_d       = fsm_q;
    phase_d     = phase_q;
    gen_d       = gen_q;
    z_d         = z_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    red_d       = red_q;
    cnt_d       = cnt_q;
    draw_sel_d  = draw_sel_q;
    lo_d        = lo_q;
    span_d      = span_q;
    secs_res_d  = secs_res_q;
    out_valid_d = out_valid_q;
    out_secs_d  = out_secs_q;
    out_tail_d  = out_tail_q;

    // The consumer drains the output register whenever it takes the transaction.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (fsm_q)
      S_IDLE: begin
        if (in_valid_i && draw_i) begin
          lo_d       = band_lo;
          span_d     = band_span;
          draw_sel_d = 1'b0;
          fsm_d      = S_ADV;
        end
      end
      S_ADV: begin
        gen_d   = gen_start + GOLDEN_GAMMA;
        phase_d = PH_PRE;
        fsm_d   = S_XOR;
      end
      S_XOR: begin
        unique case (phase_q)
          PH_PRE: begin
            z_d   = gen_q ^ (gen_q >> 30);
            fsm_d = S_MUL0;
          end
          PH_MID: begin
            z_d   = acc_q ^ (acc_q >> 27);
            fsm_d = S_MUL0;
          end
          default: begin
            z_d = acc_q ^ (acc_q >> 31);
            if (!draw_sel_q) begin
              rem_d = 30'd0;
              cnt_d = 5'd0;
              fsm_d = S_MOD;
            end else begin
              fsm_d = S_RCP0;
            end
          end
        endcase
      end
      S_MUL0: begin
        fsm_d = S_MUL1;
      end
      S_MUL1: begin
        acc_d = mul_p;
        fsm_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
        fsm_d = S_MUL3;
      end
      S_MUL3: begin
        acc_d   = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
        phase_d = (phase_q == PH_PRE) ? PH_MID : PH_FIN;
        fsm_d   = S_XOR;
      end
      S_MOD: begin
        z_d   = {z_q[61:0], 2'b00};
        rem_d = rem_next;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          secs_res_d = rem_next[4:0] + lo_q;
          draw_sel_d = 1'b1;
          fsm_d      = S_ADV;
        end
      end
      S_RCP0: begin
        fsm_d = S_RCP1;
      end
      S_RCP1: begin
        fsm_d = S_RCP2;
      end
      S_RCP2: begin
        red_d = z_q[33:0] - mul_p[33:0];
        cnt_d = 5'd0;
        fsm_d = S_SUB;
      end
      S_SUB: begin
        if (red_q >= sub_k) begin
          red_d = red_q - sub_k;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          fsm_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_secs_d  = secs_res_q;
          out_tail_d  = red_q[29:0];
          fsm_d       = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  // Control state, including the generator state whose zero value marks it unseeded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      phase_q     <= PH_PRE;
      gen_q       <= 64'd0;
      cnt_q       <= 5'd0;
      draw_sel_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      phase_q     <= phase_d;
      gen_q       <= gen_d;
      cnt_q       <= cnt_d;
      draw_sel_q  <= draw_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath payload.
  always_ff @(posedge clk_i) begin
    z_q        <= z_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    red_q      <= red_d;
    lo_q       <= lo_d;
    span_q     <= span_d;
    secs_res_q <= secs_res_d;
    out_secs_q <= out_secs_d;
    out_tail_q <= out_tail_d;
  end

  assign in_ready_o         = (fsm_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign wait_seconds_o     = out_secs_q;
  assign tail_nanoseconds_o = out_tail_q;

endmodule

`default_nettype wire
